// ----- hw/rtl/l4fp_pkg.sv -----
// Package for the layer-4 flow parser and backend selector.
// Holds word types, opcodes, reason codes and the controller/datapath links.
// No dependencies.
package l4fp_pkg;

    localparam int SERVICE_SLOTS_DEF        = 16;
    localparam int BACKENDS_PER_SERVICE_DEF = 16;
    localparam int HEADER_BYTES_DEF         = 96;
    localparam int CNT_W                    = 9;

    localparam logic [1:0] OP_FRAME   = 2'd0;
    localparam logic [1:0] OP_SERVICE = 2'd1;
    localparam logic [1:0] OP_BACKEND = 2'd2;

    localparam logic [3:0] REASON_OK         = 4'd0;
    localparam logic [3:0] REASON_SHORT_ETH  = 4'd1;
    localparam logic [3:0] REASON_NOT_IPV4   = 4'd2;
    localparam logic [3:0] REASON_SHORT_IP   = 4'd3;
    localparam logic [3:0] REASON_NOT_L4     = 4'd4;
    localparam logic [3:0] REASON_SHORT_L4   = 4'd5;
    localparam logic [3:0] REASON_NO_SERVICE = 4'd6;
    localparam logic [3:0] REASON_NO_BACKEND = 4'd7;
    localparam logic [3:0] REASON_BE_MISSING = 4'd8;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [7:0]  slot_index;
        logic [31:0] svc_address;
        logic [15:0] svc_port;
        logic [7:0]  svc_protocol;
        logic [4:0]  svc_backends;
        logic        entry_valid;
        logic [47:0] backend_address;
    } in_word_t;

    typedef struct packed {
        logic        verdict;
        logic [3:0]  reason;
        logic [31:0] flow_hash;
        logic [3:0]  matched_service;
        logic [3:0]  chosen_backend;
        logic [47:0] new_dest_mac;
        logic [47:0] new_source_mac;
    } out_word_t;

    typedef struct packed {
        logic             capture;
        logic             wr_svc;
        logic             wr_be;
        logic             hash_init;
        logic             hash_step;
        logic             scan_rd;
        logic             svc_take;
        logic             div_init;
        logic             div_step;
        logic             be_read;
        logic             finish;
        logic [3:0]       reason;
        logic [CNT_W-1:0] count;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [3:0] pre_reason;
        logic       match;
        logic       bcnt_zero;
        logic       be_valid;
    } dp_status_t;

endpackage

// ----- hw/rtl/l4fp_ctrl.sv -----
// Controller state machine of the flow parser: handshakes and sequencing.
// Depends on l4fp_pkg.
module l4fp_ctrl #(
    parameter int SERVICE_SLOTS = l4fp_pkg::SERVICE_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [1:0]             opcode,
    input  logic                   frame_end,
    output logic                   result_valid,
    input  logic                   result_stall,
    input  l4fp_pkg::dp_status_t   status,
    output l4fp_pkg::ctrl_cmd_t    cmd
);
    import l4fp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_HASH = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_BRD  = 3'd5;
    localparam logic [2:0] ST_BCHK = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE) ||
                     (out_valid_reg && opcode == OP_FRAME && frame_end);
        accept     = item_valid && !item_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.count  = cnt_reg;
        cmd.capture = accept && opcode == OP_FRAME;
        cmd.wr_svc  = accept && opcode == OP_SERVICE;
        cmd.wr_be   = accept && opcode == OP_BACKEND;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_FRAME && frame_end)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.pre_reason != REASON_OK)
                begin
                    cmd.finish = 1'b1;
                    cmd.reason = status.pre_reason;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.hash_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (cnt_reg == CNT_W'(6))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != '0 && status.match)
                begin
                    cmd.svc_take = 1'b1;
                    if (status.bcnt_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.reason = REASON_NO_BACKEND;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.div_init = 1'b1;
                        cnt_next     = '0;
                        state_next   = ST_DIV;
                    end
                end
                else if (cnt_reg == CNT_W'(SERVICE_SLOTS))
                begin
                    cmd.finish = 1'b1;
                    cmd.reason = REASON_NO_SERVICE;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(31))
                begin
                    state_next = ST_BRD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_BRD:
            begin
                cmd.be_read = 1'b1;
                state_next  = ST_BCHK;
            end
            ST_BCHK:
            begin
                cmd.finish = 1'b1;
                cmd.reason = status.be_valid ? REASON_OK : REASON_BE_MISSING;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/l4fp_dpath.sv -----
// Datapath of the flow parser: header capture, checks, jhash, service scan,
// modulo divider, backend table and result word. Depends on l4fp_pkg.
module l4fp_dpath #(
    parameter int SERVICE_SLOTS        = l4fp_pkg::SERVICE_SLOTS_DEF,
    parameter int BACKENDS_PER_SERVICE = l4fp_pkg::BACKENDS_PER_SERVICE_DEF,
    parameter int HEADER_BYTES         = l4fp_pkg::HEADER_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  l4fp_pkg::in_word_t   item,
    input  l4fp_pkg::ctrl_cmd_t  cmd,
    output l4fp_pkg::dp_status_t status,
    output l4fp_pkg::out_word_t  result
);
    import l4fp_pkg::*;

    localparam int BSLOTS = SERVICE_SLOTS * BACKENDS_PER_SERVICE;
    localparam int SW     = (SERVICE_SLOTS > 1) ? $clog2(SERVICE_SLOTS) : 1;
    localparam int BW     = (BSLOTS > 1) ? $clog2(BSLOTS) : 1;

    logic [15:0] byte_count_reg;
    logic [15:0] len_reg;
    logic [47:0] dmac_reg;
    logic [15:0] etype_reg;
    logic [3:0]  ihl_reg;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [31:0] ports_reg;

    logic [15:0] idx;
    logic [15:0] count_inc;
    logic [3:0]  cur_ihl;
    logic [15:0] off_cap;
    logic [15:0] off_chk;
    logic [15:0] need_l4;
    logic [3:0]  pre_reason;

    logic [31:0] a_reg, b_reg, c_reg, seed;

    logic [31:0] svc_addr_mem  [SERVICE_SLOTS];
    logic [15:0] svc_port_mem  [SERVICE_SLOTS];
    logic [7:0]  svc_proto_mem [SERVICE_SLOTS];
    logic [4:0]  svc_cnt_mem   [SERVICE_SLOTS];
    logic [SERVICE_SLOTS-1:0] svc_valid_reg;
    logic [31:0] svc_rd_addr_reg;
    logic [15:0] svc_rd_port_reg;
    logic [7:0]  svc_rd_proto_reg;
    logic [4:0]  svc_rd_cnt_reg;
    logic        svc_rd_valid_reg;
    logic [SW-1:0] svc_rd_idx_reg;
    logic [SW-1:0] svc_idx_reg;
    logic [4:0]  bcnt_reg;
    logic [4:0]  bcnt_wr;
    logic [SW-1:0] scan_addr;

    logic [31:0] dsh_reg;
    logic [4:0]  rem_reg;
    logic [5:0]  trial;

    logic [47:0] be_mac_mem [BSLOTS];
    logic [BSLOTS-1:0] be_valid_reg;
    logic [47:0] be_mac_q_reg;
    logic        be_valid_q_reg;
    logic [31:0] be_idx_full;
    logic [BW-1:0] be_addr;
    logic [BW-1:0] be_wr_addr;

    always_comb
    begin
        idx       = byte_count_reg;
        count_inc = (byte_count_reg == 16'hFFFF) ? byte_count_reg : byte_count_reg + 16'd1;
        cur_ihl   = (idx == 16'd14) ? item.frame_byte[3:0] : ihl_reg;
        off_cap   = 16'd14 + {10'd0, cur_ihl, 2'b00};
        off_chk   = 16'd14 + {10'd0, ihl_reg, 2'b00};
        need_l4   = off_chk + ((proto_reg == PROTO_TCP) ? 16'd20 : 16'd8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
        end
        else if (cmd.capture)
        begin
            byte_count_reg <= item.frame_end ? 16'd0 : count_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            if (item.frame_end)
            begin
                len_reg <= count_inc;
            end
            if (32'(idx) < HEADER_BYTES)
            begin
                if (idx < 16'd6)
                begin
                    dmac_reg[(3'd5 - idx[2:0]) * 8 +: 8] <= item.frame_byte;
                end
                if (idx == 16'd12)
                begin
                    etype_reg[15:8] <= item.frame_byte;
                end
                if (idx == 16'd13)
                begin
                    etype_reg[7:0] <= item.frame_byte;
                end
                if (idx == 16'd14)
                begin
                    ihl_reg <= item.frame_byte[3:0];
                end
                if (idx == 16'd23)
                begin
                    proto_reg <= item.frame_byte;
                end
                if (idx >= 16'd26 && idx < 16'd30)
                begin
                    src_reg[2'(2'd1 - idx[1:0]) * 8 +: 8] <= item.frame_byte;
                end
                if (idx >= 16'd30 && idx < 16'd34)
                begin
                    dst_reg[2'(2'd1 - idx[1:0]) * 8 +: 8] <= item.frame_byte;
                end
                if (idx >= off_cap && idx < off_cap + 16'd4)
                begin
                    ports_reg[2'(2'd3 - (idx[1:0] - off_cap[1:0])) * 8 +: 8] <= item.frame_byte;
                end
            end
        end
    end

    always_comb
    begin
        if (len_reg < 16'd14)
            pre_reason = REASON_SHORT_ETH;
        else if (etype_reg != 16'h0800)
            pre_reason = REASON_NOT_IPV4;
        else if (len_reg < 16'd34 || len_reg < off_chk)
            pre_reason = REASON_SHORT_IP;
        else if (proto_reg != PROTO_TCP && proto_reg != PROTO_UDP)
            pre_reason = REASON_NOT_L4;
        else if (len_reg < need_l4)
            pre_reason = REASON_SHORT_L4;
        else
            pre_reason = REASON_OK;
    end

    assign status.pre_reason = pre_reason;

    assign seed = {24'd0, proto_reg} + 32'hdeadbeef + 32'd12;

    always_ff @(posedge clk)
    begin
        if (cmd.hash_init)
        begin
            a_reg <= {src_reg[7:0], src_reg[15:8], src_reg[23:16], src_reg[31:24]} + seed;
            b_reg <= {dst_reg[7:0], dst_reg[15:8], dst_reg[23:16], dst_reg[31:24]} + seed;
            c_reg <= {ports_reg[23:16], ports_reg[31:24], ports_reg[7:0], ports_reg[15:8]}
                     + seed;
        end
        else if (cmd.hash_step)
        begin
            case (cmd.count[2:0])
                3'd0: c_reg <= (c_reg ^ b_reg) - {b_reg[17:0], b_reg[31:18]};
                3'd1: a_reg <= (a_reg ^ c_reg) - {c_reg[20:0], c_reg[31:21]};
                3'd2: b_reg <= (b_reg ^ a_reg) - {a_reg[6:0], a_reg[31:7]};
                3'd3: c_reg <= (c_reg ^ b_reg) - {b_reg[15:0], b_reg[31:16]};
                3'd4: a_reg <= (a_reg ^ c_reg) - {c_reg[27:0], c_reg[31:28]};
                3'd5: b_reg <= (b_reg ^ a_reg) - {a_reg[17:0], a_reg[31:18]};
                3'd6: c_reg <= (c_reg ^ b_reg) - {b_reg[7:0], b_reg[31:8]};
                default: c_reg <= c_reg;
            endcase
        end
    end

    assign bcnt_wr   = (32'(item.svc_backends) > BACKENDS_PER_SERVICE) ?
                       5'(BACKENDS_PER_SERVICE) : item.svc_backends;
    assign scan_addr = cmd.count[SW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_svc && 32'(item.slot_index) < SERVICE_SLOTS)
        begin
            svc_addr_mem[item.slot_index[SW-1:0]]  <= item.svc_address;
            svc_port_mem[item.slot_index[SW-1:0]]  <= item.svc_port;
            svc_proto_mem[item.slot_index[SW-1:0]] <= item.svc_protocol;
            svc_cnt_mem[item.slot_index[SW-1:0]]   <= bcnt_wr;
        end
        if (cmd.scan_rd)
        begin
            svc_rd_addr_reg  <= svc_addr_mem[scan_addr];
            svc_rd_port_reg  <= svc_port_mem[scan_addr];
            svc_rd_proto_reg <= svc_proto_mem[scan_addr];
            svc_rd_cnt_reg   <= svc_cnt_mem[scan_addr];
            svc_rd_idx_reg   <= scan_addr;
        end
        if (cmd.svc_take)
        begin
            svc_idx_reg <= svc_rd_idx_reg;
            bcnt_reg    <= svc_rd_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svc_valid_reg    <= '0;
            svc_rd_valid_reg <= 1'b0;
            be_valid_reg     <= '0;
            be_valid_q_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.wr_svc && 32'(item.slot_index) < SERVICE_SLOTS)
            begin
                svc_valid_reg[item.slot_index[SW-1:0]] <= item.entry_valid;
            end
            if (cmd.scan_rd)
            begin
                svc_rd_valid_reg <= svc_valid_reg[scan_addr];
            end
            if (cmd.wr_be && 32'(item.slot_index) < BSLOTS)
            begin
                be_valid_reg[be_wr_addr] <= item.entry_valid;
            end
            if (cmd.be_read)
            begin
                be_valid_q_reg <= be_valid_reg[be_addr];
            end
        end
    end

    assign status.match = svc_rd_valid_reg && svc_rd_addr_reg == dst_reg &&
                          svc_rd_port_reg == ports_reg[15:0] &&
                          svc_rd_proto_reg == proto_reg;
    assign status.bcnt_zero = (svc_rd_cnt_reg == 5'd0);

    assign trial = {rem_reg, dsh_reg[31]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            dsh_reg <= c_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dsh_reg <= {dsh_reg[30:0], 1'b0};
            rem_reg <= (trial >= {1'b0, bcnt_reg}) ? 5'(trial - {1'b0, bcnt_reg})
                                                    : trial[4:0];
        end
    end

    assign be_idx_full = 32'(svc_idx_reg) * BACKENDS_PER_SERVICE + 32'(rem_reg);
    assign be_addr     = be_idx_full[BW-1:0];
    assign be_wr_addr  = BW'(item.slot_index);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_be && 32'(item.slot_index) < BSLOTS)
        begin
            be_mac_mem[be_wr_addr] <= item.backend_address;
        end
        if (cmd.be_read)
        begin
            be_mac_q_reg <= be_mac_mem[be_addr];
        end
    end

    assign status.be_valid = be_valid_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result.verdict         <= (cmd.reason == REASON_OK);
            result.reason          <= cmd.reason;
            result.flow_hash       <= (cmd.reason == REASON_OK ||
                                       cmd.reason >= REASON_NO_SERVICE) ? c_reg : 32'd0;
            result.matched_service <= (cmd.reason == REASON_OK ||
                                       cmd.reason >= REASON_NO_BACKEND) ?
                                      4'(cmd.svc_take ? svc_rd_idx_reg : svc_idx_reg) : 4'd0;
            result.chosen_backend  <= (cmd.reason == REASON_OK ||
                                       cmd.reason >= REASON_BE_MISSING) ? rem_reg[3:0] : 4'd0;
            result.new_dest_mac    <= (cmd.reason == REASON_OK) ? be_mac_q_reg : 48'd0;
            result.new_source_mac  <= (cmd.reason == REASON_OK) ? dmac_reg : 48'd0;
        end
    end

endmodule

// ----- hw/rtl/l4_flow_parse_hash_select.sv -----
// Top level of the layer-4 flow parser, hash and backend selector.
// Joins l4fp_ctrl and l4fp_dpath; depends on l4fp_pkg.
//
// Use: items enter on item/item_valid/item_stall, one word per accepted edge.
// A frame byte word (opcode 0) is taken each cycle while the block is idle; service and backend
// writes (opcodes 1 and 2) give no result.
// On the word that carries frame_end the block stops taking words and works:
//   early header failure: the evaluation step, then the result;
//   otherwise evaluation, 7 hash rounds, a scan of the service table (one
//   service entry per cycle through the table's read port), a bit-serial divider
//   (one remainder bit per cycle), a backend read and a backend check.
// One result word per frame appears on result/result_valid and holds while
// result_stall is high; frame bytes and table writes are still taken then,
// but a further last byte waits until the pending result is taken.
// Reset clears the byte count, the valid bits of both tables and the
// handshakes; table contents stay undefined until written.
module l4_flow_parse_hash_select #(
    parameter int SERVICE_SLOTS        = l4fp_pkg::SERVICE_SLOTS_DEF,
    parameter int BACKENDS_PER_SERVICE = l4fp_pkg::BACKENDS_PER_SERVICE_DEF,
    parameter int HEADER_BYTES         = l4fp_pkg::HEADER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  l4fp_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output l4fp_pkg::out_word_t result
);
    import l4fp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    l4fp_ctrl #(
        .SERVICE_SLOTS(SERVICE_SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .opcode      (item.opcode),
        .frame_end   (item.frame_end),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .status      (status),
        .cmd         (cmd)
    );

    l4fp_dpath #(
        .SERVICE_SLOTS       (SERVICE_SLOTS),
        .BACKENDS_PER_SERVICE(BACKENDS_PER_SERVICE),
        .HEADER_BYTES        (HEADER_BYTES)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd),
        .status(status),
        .result(result)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for l4_flow_parse_hash_select: frame parsing, service
// lookup, jhash backend selection, table writes and handshake stalls on both channels.
// Depends on l4fp_pkg and the RTL of the block; the predictor below is written locally.
`timescale 1ns / 100ps

module testbench;
    import l4fp_pkg::*;

    localparam int NSVC = 16;
    localparam int NBE = 16;
    localparam int HDR = 96;
    localparam int LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    in_word_t item;
    logic result_valid;
    logic result_stall;
    out_word_t result;

    l4_flow_parse_hash_select u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    // predictor state
    logic [7:0] hdr_bytes[HDR];
    int unsigned frame_len;
    logic svc_ok[NSVC];
    logic [31:0] svc_ip[NSVC];
    logic [15:0] svc_pt[NSVC];
    logic [7:0] svc_pr[NSVC];
    logic [4:0] svc_cnt[NSVC];
    logic be_ok[NSVC*NBE];
    logic [47:0] be_mac[NSVC*NBE];

    out_word_t verdict_q[$];
    int errors;
    int items_sent;
    int results_seen;
    int frames_sent;
    int cycles;
    int hold_left;
    int hold_reqs;
    int hold_done;
    bit quiet;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rol(logic [31:0] x, int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] jhash3(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                           logic [31:0] iv);
        logic [31:0] s;
        s = iv + 32'hdeadbeef + 32'd12;
        a += s; b += s; c += s;
        c ^= b; c -= rol(b, 14);
        a ^= c; a -= rol(c, 11);
        b ^= a; b -= rol(a, 25);
        c ^= b; c -= rol(b, 16);
        a ^= c; a -= rol(c, 4);
        b ^= a; b -= rol(a, 14);
        c ^= b; c -= rol(b, 24);
        return c;
    endfunction

    function automatic logic [7:0] hb(int unsigned i);
        return (i < HDR) ? hdr_bytes[i] : 8'd0;
    endfunction

    function automatic out_word_t judge_frame(int unsigned len);
        out_word_t r;
        logic [3:0] why;
        int unsigned off;
        int unsigned idx;
        logic [7:0] pr;
        logic [7:0] b14;
        logic [31:0] h;
        logic [31:0] daddr;
        logic [15:0] dport;
        int sv;
        int pick;
        logic [47:0] dm;
        logic [47:0] sm;
        h = '0; sv = 0; pick = 0; dm = '0; sm = '0;
        why = REASON_OK;
        b14 = hb(14);
        off = 14 + 4 * b14[3:0];
        pr = hb(23);
        if (len < 14) why = REASON_SHORT_ETH;
        else if (hb(12) != 8'h08 || hb(13) != 8'h00) why = REASON_NOT_IPV4;
        else if (len < 34 || len < off) why = REASON_SHORT_IP;
        else if (pr != PROTO_TCP && pr != PROTO_UDP) why = REASON_NOT_L4;
        else if (len < off + ((pr == PROTO_TCP) ? 20 : 8)) why = REASON_SHORT_L4;
        else
        begin
            h = jhash3({hb(29), hb(28), hb(27), hb(26)}, {hb(33), hb(32), hb(31), hb(30)},
                       {hb(off + 1), hb(off), hb(off + 3), hb(off + 2)}, {24'd0, pr});
            daddr = {hb(30), hb(31), hb(32), hb(33)};
            dport = {hb(off + 2), hb(off + 3)};
            sv = -1;
            for (int i = NSVC - 1; i >= 0; i--)
                if (svc_ok[i] && svc_ip[i] == daddr && svc_pt[i] == dport && svc_pr[i] == pr)
                    sv = i;
            if (sv < 0)
            begin
                why = REASON_NO_SERVICE;
                sv = 0;
            end
            else if (svc_cnt[sv] == 0) why = REASON_NO_BACKEND;
            else
            begin
                pick = h % svc_cnt[sv];
                idx = sv * NBE + pick;
                if (!be_ok[idx]) why = REASON_BE_MISSING;
                else
                begin
                    dm = be_mac[idx];
                    sm = {hb(0), hb(1), hb(2), hb(3), hb(4), hb(5)};
                end
            end
        end
        r.verdict = (why == REASON_OK);
        r.reason = why;
        r.flow_hash = (why == REASON_OK || why >= REASON_NO_SERVICE) ? h : '0;
        r.matched_service = (why == REASON_OK || why >= REASON_NO_BACKEND) ? sv[3:0] : '0;
        r.chosen_backend = (why == REASON_OK || why >= REASON_BE_MISSING) ? pick[3:0] : '0;
        r.new_dest_mac = dm;
        r.new_source_mac = sm;
        return r;
    endfunction

    function automatic void predict_word(in_word_t w);
        logic [4:0] n;
        if (w.opcode == OP_FRAME)
        begin
            if (frame_len < HDR) hdr_bytes[frame_len] = w.frame_byte;
            if (frame_len < 65535) frame_len++;
            if (w.frame_end)
            begin
                verdict_q.push_back(judge_frame(frame_len));
                frame_len = 0;
            end
        end
        else if (w.opcode == OP_SERVICE)
        begin
            if (w.slot_index < NSVC)
            begin
                n = (w.svc_backends > NBE) ? 5'(NBE) : w.svc_backends;
                svc_ok[w.slot_index] = w.entry_valid;
                svc_ip[w.slot_index] = w.svc_address;
                svc_pt[w.slot_index] = w.svc_port;
                svc_pr[w.slot_index] = w.svc_protocol;
                svc_cnt[w.slot_index] = n;
            end
        end
        else if (w.opcode == OP_BACKEND)
        begin
            be_ok[w.slot_index] = w.entry_valid;
            be_mac[w.slot_index] = w.backend_address;
        end
    endfunction

    // receiver stall: hold for a long stretch on request, else random (never while quiet)
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_reqs != hold_done)
        begin
            result_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end
        else
            result_stall <= quiet ? 1'b0 : ($urandom_range(99) < 24);
    end

    always @(negedge clk)
    begin
        out_word_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (verdict_q.size() == 0)
            begin
                $error("result word with nothing expected: %h", result);
                errors++;
            end
            else
            begin
                e = verdict_q.pop_front();
                if (e.verdict !== result.verdict)
                begin
                    $error("verdict exp %h act %h", e.verdict, result.verdict); errors++;
                end
                if (e.reason !== result.reason)
                begin
                    $error("reason exp %h act %h", e.reason, result.reason); errors++;
                end
                if (e.flow_hash !== result.flow_hash)
                begin
                    $error("flow_hash exp %h act %h", e.flow_hash, result.flow_hash); errors++;
                end
                if (e.matched_service !== result.matched_service)
                begin
                    $error("matched_service exp %h act %h", e.matched_service,
                           result.matched_service);
                    errors++;
                end
                if (e.chosen_backend !== result.chosen_backend)
                begin
                    $error("chosen_backend exp %h act %h", e.chosen_backend,
                           result.chosen_backend);
                    errors++;
                end
                if (e.new_dest_mac !== result.new_dest_mac)
                begin
                    $error("new_dest_mac exp %h act %h", e.new_dest_mac, result.new_dest_mac);
                    errors++;
                end
                if (e.new_source_mac !== result.new_source_mac)
                begin
                    $error("new_source_mac exp %h act %h", e.new_source_mac,
                           result.new_source_mac);
                    errors++;
                end
            end
        end
    end

    function automatic in_word_t noise_word();
        logic [159:0] raw;
        in_word_t w;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(in_word_t)-1:0];
        return w;
    endfunction

    // hold valid across back-to-back words; unless quiet, drop it for a cycle now and then
    task automatic send_word(in_word_t w);
        bit taken;
        item <= w;
        item_valid <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !item_stall;
            if (taken)
            begin
                predict_word(w);
                items_sent++;
            end
            @(posedge clk);
        end
        if (!quiet && $urandom_range(99) < 30)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_service(int slot, logic [31:0] ip, logic [15:0] pt, logic [7:0] pr,
                                 logic [4:0] cnt, logic ok);
        in_word_t w;
        w = noise_word();
        w.opcode = OP_SERVICE;
        w.slot_index = slot[7:0];
        w.svc_address = ip;
        w.svc_port = pt;
        w.svc_protocol = pr;
        w.svc_backends = cnt;
        w.entry_valid = ok;
        send_word(w);
    endtask

    task automatic write_backend(int slot, logic ok);
        in_word_t w;
        w = noise_word();
        w.opcode = OP_BACKEND;
        w.slot_index = slot[7:0];
        w.entry_valid = ok;
        send_word(w);
    endtask

    // one frame; backend table words may be slipped in between its bytes
    task automatic send_frame(int len, logic [15:0] etype, logic [3:0] ihl, logic [7:0] pr,
                              logic [31:0] daddr, logic [15:0] dport, bit mix_tables);
        logic [7:0] fb[];
        int off;
        in_word_t w;
        fb = new[len];
        foreach (fb[i]) fb[i] = 8'($urandom);
        off = 14 + 4 * ihl;
        if (len > 13) {fb[12], fb[13]} = etype;
        if (len > 14) fb[14][3:0] = ihl;
        if (len > 23) fb[23] = pr;
        if (len > 33) {fb[30], fb[31], fb[32], fb[33]} = daddr;
        if (len > off + 3) {fb[off + 2], fb[off + 3]} = dport;
        for (int i = 0; i < len; i++)
        begin
            if (mix_tables && $urandom_range(99) < 3)
                write_backend($urandom_range(255), 1'($urandom));
            w = noise_word();
            w.opcode = OP_FRAME;
            w.frame_byte = fb[i];
            w.frame_end = (i == len - 1);
            send_word(w);
        end
        frames_sent++;
    endtask

    task automatic send_good(int slot, int len, bit mix_tables);
        logic [3:0] ihl;
        int need;
        ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 8)) : 4'd5;
        need = 14 + 4 * ihl + ((svc_pr[slot] == PROTO_TCP) ? 20 : 8);
        if (len < need) len = need;
        send_frame(len, 16'h0800, ihl, svc_pr[slot], svc_ip[slot], svc_pt[slot], mix_tables);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic test_tables();
        in_word_t w;
        write_service(0, 32'h0a000001, 16'h0050, PROTO_TCP, 5'd16, 1'b1);
        write_service(1, 32'hc0a80102, 16'h0035, PROTO_UDP, 5'd5, 1'b1);
        write_service(2, 32'h0a000003, 16'h1f90, PROTO_TCP, 5'd0, 1'b1);
        write_service(3, 32'hffffffff, 16'hffff, PROTO_UDP, 5'd16, 1'b1);
        write_service(4, 32'h00000000, 16'h0000, PROTO_TCP, 5'd31, 1'b1);
        write_service(5, 32'h00000000, 16'h0000, PROTO_TCP, 5'd3, 1'b1);
        write_service(6, 32'h0a000007, 16'h0bb8, PROTO_UDP, 5'd17, 1'b1);
        write_service(7, 32'h0a000008, 16'h0bb8, PROTO_TCP, 5'd1, 1'b0);
        for (int s = 8; s < NSVC; s++)
            write_service(s, $urandom, 16'($urandom),
                          $urandom_range(1) ? PROTO_TCP : PROTO_UDP,
                          5'($urandom_range(1, 16)), 1'b1);
        write_service(200, 32'h0a000001, 16'h0050, PROTO_TCP, 5'd1, 1'b1);
        for (int b = 0; b < 5 * NBE; b++)
            write_backend(b, (b / NBE == 3) ? b[0] : 1'b1);
        w = noise_word();
        w.opcode = OP_UNUSED;
        send_word(w);
        drain();
    endtask

    task automatic test_header_checks();
        send_frame(1, 16'h0800, 4'd5, PROTO_TCP, 32'd0, 16'd0, 1'b0);
        send_frame(13, 16'h0800, 4'd5, PROTO_TCP, 32'd0, 16'd0, 1'b0);
        send_frame(14, 16'h0800, 4'd5, PROTO_TCP, 32'd0, 16'd0, 1'b0);
        send_frame(20, 16'h86dd, 4'd5, PROTO_TCP, 32'd0, 16'd0, 1'b0);
        send_frame(33, 16'h0800, 4'd5, PROTO_TCP, 32'd0, 16'd0, 1'b0);
        send_frame(50, 16'h0800, 4'd15, PROTO_TCP, 32'd0, 16'd0, 1'b0);
        send_frame(40, 16'h0800, 4'd0, PROTO_UDP, 32'h0a000001, 16'd0, 1'b0);
        send_frame(34, 16'h0800, 4'd5, 8'd1, 32'd0, 16'd0, 1'b0);
        send_frame(53, 16'h0800, 4'd5, PROTO_TCP, 32'd0, 16'd0, 1'b0);
        send_frame(41, 16'h0800, 4'd5, PROTO_UDP, 32'd0, 16'd0, 1'b0);
        send_frame(54, 16'h0800, 4'd5, PROTO_TCP, 32'h01020304, 16'h0001, 1'b0);
        drain();
    endtask

    task automatic test_selection();
        quiet = 1'b1;
        send_good(0, 54, 1'b0);
        send_good(1, 42, 1'b0);
        send_good(2, 54, 1'b0);
        send_good(3, 42, 1'b0);
        send_good(4, 60, 1'b0);
        send_good(6, 42, 1'b0);
        send_good(7, 54, 1'b0);
        send_good(0, 100, 1'b0);
        send_good(1, 64, 1'b1);
        drain();
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_reqs++;
        for (int i = 0; i < 3; i++) send_good($urandom_range(1), 42, 1'b0);
        drain();
    endtask

    task automatic test_random();
        int s;
        int len;
        while (items_sent < 1260)
        begin
            s = $urandom_range(NSVC - 1);
            len = $urandom_range(99) < 70 ? $urandom_range(42, 70) : $urandom_range(1, 130);
            case ($urandom_range(9))
                0: send_frame(len, $urandom_range(1) ? 16'h0800 : 16'($urandom),
                              4'($urandom), 8'($urandom), $urandom, 16'($urandom), 1'b1);
                1: write_service($urandom_range(8, 20), $urandom, 16'($urandom),
                                 $urandom_range(1) ? PROTO_TCP : PROTO_UDP,
                                 5'($urandom), $urandom_range(3) != 0);
                2: send_word(noise_word());
                default: send_good(s, len, 1'b1);
            endcase
        end
        drain();
    endtask

    initial
    begin
        items_sent = 0; frames_sent = 0; hold_reqs = 0;
        quiet = 1'b0; frame_len = 0;
        foreach (svc_ok[i]) svc_ok[i] = 1'b0;
        foreach (be_ok[i]) be_ok[i] = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_tables();
        test_header_checks();
        test_selection();
        test_backpressure();
        test_random();
        $display("Covered %0d words, %0d frames and %0d checked verdicts,", items_sent,
                 frames_sent, results_seen);
        $display("with header faults, service lookup, backend choice and stalls.");
        if (errors == 0 && verdict_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
